/* hdl/multi_channel_square_tone_mixer_macros.svh */
// assertion helpers shared by the tone mixer rtl
`ifndef MULTI_CHANNEL_SQUARE_TONE_MIXER_MACROS_SVH
`define MULTI_CHANNEL_SQUARE_TONE_MIXER_MACROS_SVH

// same-cycle implication, checked on rising clk outside reset
`define MCTM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mctm assertion failed");

// next-cycle implication
`define MCTM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mctm assertion failed");

`endif

/* hdl/mctm_pkg.sv */
package mctm_pkg;

	localparam int CHANNELS = 3;
	localparam logic [7:0] REST_CODE = 8'd255;

	localparam int LEVEL_W = 6;
	localparam int MIX_W = 10;
	localparam int FRAC_BITS = 20;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_NOTE = 1'b1
	} op_t;

	localparam logic [1:0] REG_MASTER_VOLUME = 2'd0;
	localparam logic [1:0] REG_OUTPUT_ENABLE = 2'd1;
	localparam logic [1:0] REG_LAST_VOLUME = 2'd2;

	// period at the lowest octave for each semitone, FRAC_BITS fraction bits
	// 44100*8*2^(-s/12)/440 = sd*441/5.5e9 with sd = 2^(-s/12) * 1e10
	localparam logic [31:0] BASE_PERIOD [12] = '{
		32'((64'd10000000000 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd9438743127 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd8908987181 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd8408964153 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd7937005260 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd7491535384 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd7071067812 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd6674199271 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd6299605249 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd5946035575 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd5612310242 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000),
		32'((64'd5297315472 * 64'd441 * (64'd1 << FRAC_BITS)) / 64'd5500000000)
	};

	typedef struct packed {
		logic       note_wr;
		logic       tick;
		logic [7:0] note;
		logic [1:0] vol;
	} chan_ctrl_t;

endpackage

/* hdl/multi_channel_square_tone_mixer.sv */
// a sample tick passes through the input register, which takes the request, and then the output register
// that holds the sample until the sink takes it; a held sample stalls the input register
// note events give no result
// throughput: one request per cycle while the output is not stalled
// reset: all channels rest with zero phase, master volume and enable at 0,
// last channel volume at half
`include "multi_channel_square_tone_mixer_macros.svh"

module multi_channel_square_tone_mixer
	import mctm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // note_code [7:0], channel_index [9:8], zero [15:10]
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // mixed_sample [5:0], zero [7:6]
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_wdata
);

	logic [2:0] master_volume_q;
	logic       output_enable_q;
	logic [1:0] last_volume_q;

	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] note_s1;
	logic [1:0] chan_s1;

	logic       m_tvalid_q;
	logic [5:0] sample_q;

	logic        advance;
	logic        muted;
	logic [2:0]  step;
	logic [1:0]  last_vol;
	logic [15:0] period;
	logic signed [LEVEL_W-1:0] level_sum;
	logic signed [MIX_W-1:0]   mix;
	logic [5:0]  sample;

	chan_ctrl_t        ctrl [CHANNELS];
	logic signed [2:0] chan_level [CHANNELS];

	assign advance = valid_s1 && ((op_s1 == OP_NOTE) || !m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign step = (master_volume_q > 3'd4) ? 3'd4 : master_volume_q;
	assign muted = (step == 3'd0) || !output_enable_q;
	assign last_vol = (last_volume_q > 2'd2) ? 2'd2 : last_volume_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_volume_q <= '0;
			output_enable_q <= 1'b0;
			last_volume_q <= 2'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MASTER_VOLUME: master_volume_q <= cfg_wdata;
				REG_OUTPUT_ENABLE: output_enable_q <= cfg_wdata[0];
				REG_LAST_VOLUME:   last_volume_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= op_t'(s_tuser);
			note_s1 <= s_tdata[7:0];
			chan_s1 <= s_tdata[9:8];
		end
	end

	mctm_period u_period (
		.note   (note_s1),
		.period (period)
	);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		always_comb begin
			ctrl[c].note_wr = advance && (op_s1 == OP_NOTE) && (4'(chan_s1) == 4'(c));
			ctrl[c].tick = advance && (op_s1 == OP_TICK) && !muted;
			ctrl[c].note = note_s1;
			ctrl[c].vol = (c == CHANNELS - 1) ? last_vol : 2'd1;
		end

		mctm_channel u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[c]),
			.period_in (period),
			.level     (chan_level[c])
		);
	end

	always_comb begin
		level_sum = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			level_sum = level_sum + LEVEL_W'(chan_level[c]);
		end
		mix = MIX_W'(level_sum) * $signed({{(MIX_W-3){1'b0}}, step});
		if (muted) begin
			sample = '0;
		end else if (mix > MIX_W'(31)) begin
			sample = 6'd31;
		end else if (mix < -MIX_W'(32)) begin
			sample = 6'b100000;
		end else begin
			sample = mix[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && (op_s1 == OP_TICK)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (op_s1 == OP_TICK)) begin
			sample_q <= sample;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {2'b00, sample_q};

	// a stalled input stage only happens behind a held sample
	`MCTM_ASSERT_SAME(a_stall_cause, !s_tready, valid_s1 && (op_s1 == OP_TICK) && m_tvalid_q && !m_tready)
	`MCTM_ASSERT_NEXT(a_tick_gives_sample, advance && (op_s1 == OP_TICK), m_tvalid)
	`MCTM_ASSERT_NEXT(a_muted_zero, advance && (op_s1 == OP_TICK) && muted, m_tdata == 8'd0)
	`MCTM_ASSERT_NEXT(a_note_no_sample, advance && (op_s1 == OP_NOTE) && !m_tvalid_q, !m_tvalid)

endmodule

/* hdl/mctm_period.sv */
module mctm_period
	import mctm_pkg::*;
(
	input  logic [7:0]  note,
	output logic [15:0] period
);

	logic [8:0]  ofs;
	logic [16:0] oct_prod;
	logic [4:0]  oct;
	logic [3:0]  semi;
	logic [5:0]  shamt;
	logic [31:0] half;
	logic [31:0] rounded;

	always_comb begin
		ofs = 9'(note) + 9'd3;
		// divide by 12 through reciprocal 171/2048, exact for ofs below 259
		oct_prod = 17'(ofs) * 17'd171;
		oct = oct_prod[15:11];
		semi = 4'(ofs - 9'(oct) * 9'd12);
		shamt = 6'(FRAC_BITS) + 6'(oct);
		half = 32'd1 << (shamt - 6'd1);
		rounded = (BASE_PERIOD[semi] + half) >> shamt;
		period = rounded[15:0];
	end

endmodule

/* hdl/mctm_channel.sv */
module mctm_channel
	import mctm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  chan_ctrl_t        ctrl,
	input  logic [15:0]       period_in,
	output logic signed [2:0] level
);

	logic [7:0]  note_q;
	logic [15:0] period_q;
	logic [15:0] phase_q;
	logic [15:0] phase_next;
	logic        silent;
	logic        changed;
	logic signed [2:0] vol_s;

	assign silent = (note_q == REST_CODE);
	assign changed = ctrl.note_wr && (ctrl.note != note_q);
	assign vol_s = $signed({1'b0, ctrl.vol});

	always_comb begin
		phase_next = phase_q + 16'd1;
		if (phase_next == period_q) begin
			phase_next = '0;
		end
	end

	always_comb begin
		if (silent) begin
			level = '0;
		end else if (phase_q < (period_q >> 1)) begin
			level = vol_s;
		end else begin
			level = -vol_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q <= REST_CODE;
			period_q <= '0;
			phase_q <= '0;
		end else if (changed) begin
			note_q <= ctrl.note;
			phase_q <= '0;
			period_q <= (ctrl.note == REST_CODE) ? 16'd0 : period_in;
		end else if (ctrl.tick && !silent) begin
			phase_q <= phase_next;
		end
	end

endmodule

/* dv/tone_mix_check.sv */
module tone_mix_check
	import mctm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // note_code [7:0], channel_index [9:8], zero [15:10]
	input  logic        s_tuser,   // operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // mixed_sample [5:0], zero [7:6]
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_wdata,
	output int          mismatches,
	output int          outstanding
);

	// 2^(-s/12) in units of 1e-10
	localparam longint unsigned SEMITONE_DOWN [12] = '{
		64'd10000000000, 64'd9438743127, 64'd8908987181, 64'd8408964153,
		64'd7937005260,  64'd7491535384, 64'd7071067812, 64'd6674199271,
		64'd6299605249,  64'd5946035575, 64'd5612310242, 64'd5297315472
	};

	logic [7:0]  note_of   [CHANNELS];
	logic [15:0] period_of [CHANNELS];
	logic [15:0] phase_of  [CHANNELS];
	logic [2:0]  master_reg;
	logic        enable_reg;
	logic [1:0]  last_vol_reg;

	logic signed [5:0] pending_samples [$];
	logic signed [5:0] want;

	// samples per cycle of the note, 44100 / (440 * 2^((n-33)/12)) rounded
	function automatic logic [15:0] period_for_note(logic [7:0] n);
		int unsigned      d;
		longint unsigned  num;
		longint unsigned  den;
		longint unsigned  p;
		d = int'(n) + 3;
		num = 64'd352800 * SEMITONE_DOWN[d % 12];
		den = 64'd4400000000000 << (d / 12);
		p = (num + den / 2) / den;
		if (p > 64'hFFFF)
			return 16'hFFFF;
		return p[15:0];
	endfunction

	function automatic void take_note(logic [7:0] n, logic [1:0] chan);
		if (int'(chan) >= CHANNELS || n == note_of[chan])
			return;
		note_of[chan] = n;
		phase_of[chan] = 16'd0;
		period_of[chan] = (n == REST_CODE) ? 16'd0 : period_for_note(n);
	endfunction

	function automatic logic signed [5:0] mix_next_sample();
		int          step;
		int          level;
		int          vol;
		int          mix;
		logic [15:0] nxt;
		step = (master_reg > 3'd4) ? 4 : int'(master_reg);
		if (step == 0 || !enable_reg)
			return 6'sd0;
		level = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (note_of[c] == REST_CODE)
				continue;
			if (c == CHANNELS - 1)
				vol = (last_vol_reg > 2'd2) ? 2 : int'(last_vol_reg);
			else
				vol = 1;
			if (phase_of[c] < (period_of[c] >> 1))
				level += vol;
			else
				level -= vol;
			nxt = phase_of[c] + 16'd1;
			if (nxt == period_of[c])
				nxt = 16'd0;
			phase_of[c] = nxt;
		end
		mix = level * step;
		if (mix > 31)
			mix = 31;
		if (mix < -32)
			mix = -32;
		return mix[5:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				note_of[c] = REST_CODE;
				period_of[c] = 16'd0;
				phase_of[c] = 16'd0;
			end
			master_reg = 3'd0;
			enable_reg = 1'b0;
			last_vol_reg = 2'd1;
			pending_samples.delete();
			mismatches = 0;
		end else begin
			// results leave before new requests are predicted
			if (m_tvalid && m_tready) begin
				if (pending_samples.size() == 0) begin
					$display("%0t: sample with none expected, actual %0d", $time,
						$signed(m_tdata[5:0]));
					mismatches++;
				end else begin
					want = pending_samples.pop_front();
					if (m_tdata !== {2'b00, want}) begin
						$display("%0t: mixed_sample expected %0d (0x%02h), actual 0x%02h",
							$time, want, {2'b00, want}, m_tdata);
						mismatches++;
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MASTER_VOLUME: master_reg = cfg_wdata;
					REG_OUTPUT_ENABLE: enable_reg = cfg_wdata[0];
					REG_LAST_VOLUME:   last_vol_reg = cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser) == OP_NOTE)
					take_note(s_tdata[7:0], s_tdata[9:8]);
				else
					pending_samples.push_back(mix_next_sample());
			end
		end
		outstanding = pending_samples.size();
	end

endmodule

/* dv/tb.sv */
module tb;
	import mctm_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 60;
	localparam int PHASES = 6;
	localparam logic [2:0] MASTER_PICK [PHASES] = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd3, 3'd5};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic        s_tuser = OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_MASTER_VOLUME;
	logic [2:0]  cfg_wdata = 3'd0;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	bit smooth = 1'b0;
	bit hold_req = 1'b0;

	multi_channel_square_tone_mixer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tone_mix_check i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// sample sink: random stall before each sample, or a long hold when asked
	initial begin
		int wait_n;
		forever begin
			wait_n = smooth ? 0 : $urandom_range(0, 4);
			if (hold_req) begin
				wait_n = LONG_HOLD;
				hold_req = 1'b0;
			end
			@(negedge clk);
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// valid stays high when the next request follows with no gap
	task automatic send_request(op_t op, logic [7:0] note, logic [1:0] chan);
		int gap;
		gap = smooth ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, chan, note};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		// note events give no result but may still be in flight
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [2:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_request();
		int         r;
		logic [7:0] note;
		logic [1:0] chan;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			send_request(OP_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
		end else begin
			r = $urandom_range(0, 9);
			// mostly notes whose period flips within a few dozen samples
			if (r < 7)
				note = 8'($urandom_range(40, 100));
			else if (r < 8)
				note = REST_CODE;
			else
				note = 8'($urandom_range(0, 255));
			chan = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			send_request(OP_NOTE, note, chan);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// muted after reset, phases frozen
		send_request(OP_TICK, 8'd0, 2'd0);
		send_request(OP_NOTE, 8'd33, 2'd0);
		send_request(OP_TICK, 8'hFF, 2'd3);
		settle();
		write_reg(REG_MASTER_VOLUME, 3'd4);
		write_reg(REG_OUTPUT_ENABLE, 3'd1);
		write_reg(REG_SPARE, 3'd7);
		send_request(OP_TICK, 8'd0, 2'd0);
		send_request(OP_NOTE, 8'd0, 2'd1);
		send_request(OP_NOTE, 8'd254, 2'd2);   // period rounds to zero
		send_request(OP_TICK, 8'd0, 2'd0);
		send_request(OP_NOTE, 8'd60, 2'd3);    // no such channel
		send_request(OP_NOTE, 8'd33, 2'd0);    // same note again
		repeat (2) send_request(OP_TICK, 8'd0, 2'd0);
		send_request(OP_NOTE, 8'd113, 2'd1);   // period of one sample
		repeat (2) send_request(OP_TICK, 8'd0, 2'd0);
		send_request(OP_NOTE, REST_CODE, 2'd2);
		settle();
		write_reg(REG_LAST_VOLUME, 3'd3);
		send_request(OP_NOTE, 8'd81, 2'd2);
		repeat (4) send_request(OP_TICK, 8'd0, 2'd0);
		send_request(OP_NOTE, REST_CODE, 2'd1);
		send_request(OP_TICK, 8'd0, 2'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(REG_MASTER_VOLUME, MASTER_PICK[ph]);
			write_reg(REG_OUTPUT_ENABLE, {2'($urandom_range(0, 3)), ph != 4});
			write_reg(REG_LAST_VOLUME, {1'($urandom_range(0, 1)), 2'(ph % 4)});
			smooth = (ph == 2);
			if (ph == 2) begin
				// sink holds off while ticks keep coming, so the input backs up
				hold_req = 1'b1;
				repeat (30)
					send_request(OP_TICK, 8'($urandom_range(0, 255)),
						2'($urandom_range(0, 3)));
			end
			for (int k = 0; k < 90; k++)
				random_request();
		end
		smooth = 1'b0;
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
